@@ design/iirdf1_pkg.sv @@
`default_nettype none
package iirdf1_pkg;

  // filter order, 1 to 3
  localparam int ORDER = 1;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 6;
  localparam int QUO_W     = 16;
  localparam int REM_W     = COEF_W - 1;
  localparam int DVS_W     = COEF_W;
  localparam int TAP_W     = 2;
  localparam int WARM_W    = 2;
  localparam int CNT_W     = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [ACC_W-1:0]           mag_t;
  typedef logic [DVS_W-1:0]           dvs_t;
  typedef logic [REM_W-1:0]           rem_t;
  typedef logic [QUO_W-1:0]           quo_t;
  typedef logic [TAP_W-1:0]           tap_t;
  typedef logic [WARM_W-1:0]          warm_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam tap_t  ORDER_TAP  = tap_t'(ORDER);
  localparam warm_t ORDER_WARM = warm_t'(ORDER);

  // register indexes
  localparam reg_idx_t REG_DEN0 = 3'd0;
  localparam reg_idx_t REG_NUM0 = 3'd4;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    18'sd16384, -18'sd11903, 18'sd0, 18'sd0,
    18'sd2240, 18'sd2240, 18'sd0, 18'sd0
  };

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam quo_t    QUO_POS_LIM = 16'd32767;
  localparam quo_t    QUO_NEG_LIM = 16'd32768;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    tap_t tap;
    logic fb;
    logic acc;
    logic check;
    logic div;
    logic commit;
    logic zero;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ovf;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/iirdf1_ctrl.sv @@
`default_nettype none
module iirdf1_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire iirdf1_pkg::status_t status,
  output iirdf1_pkg::cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ACC   = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                state, state_next;
  iirdf1_pkg::tap_t      tap, tap_next;
  logic                  fb, fb_next;
  iirdf1_pkg::cnt_t      div_cnt, div_cnt_next;
  iirdf1_pkg::warm_t     warm_cnt, warm_cnt_next;
  logic                  warm_item, warm_item_next;

  assign in_ready = (state == S_IDLE);

  // sequencing: multiply-accumulate over taps, range check, divide, commit; warm-up words go straight to commit
  always_comb begin
    state_next     = state;
    tap_next       = tap;
    fb_next        = fb;
    div_cnt_next   = div_cnt;
    warm_cnt_next  = warm_cnt;
    warm_item_next = warm_item;
    cmd            = '0;
    cmd.tap        = tap;
    cmd.fb         = fb;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (warm_cnt < iirdf1_pkg::ORDER_WARM) begin
            warm_cnt_next  = warm_cnt + 1'b1;
            warm_item_next = 1'b1;
            state_next     = S_OUT;
          end else begin
            warm_item_next = 1'b0;
            tap_next       = '0;
            fb_next        = 1'b0;
            state_next     = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (tap == iirdf1_pkg::ORDER_TAP && fb) begin
          state_next = S_CHECK;
        end else if (tap == '0) begin
          tap_next   = tap + 1'b1;
          fb_next    = 1'b0;
          state_next = S_MUL;
        end else if (!fb) begin
          fb_next    = 1'b1;
          state_next = S_MUL;
        end else begin
          tap_next   = tap + 1'b1;
          fb_next    = 1'b0;
          state_next = S_MUL;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.ovf) begin
          state_next = S_OUT;
        end else begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div      = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == '1) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          cmd.zero   = warm_item;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap       <= '0;
      fb        <= 1'b0;
      div_cnt   <= '0;
      warm_cnt  <= '0;
      warm_item <= 1'b0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      fb        <= fb_next;
      div_cnt   <= div_cnt_next;
      warm_cnt  <= warm_cnt_next;
      warm_item <= warm_item_next;
    end
  end

endmodule
`default_nettype wire

@@ design/iirdf1_datapath.sv @@
`default_nettype none
module iirdf1_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire iirdf1_pkg::cmd_t         cmd,
  output iirdf1_pkg::status_t           status,
  input  wire iirdf1_pkg::sample_t      in_sample,
  output iirdf1_pkg::sample_t           out_sample,
  output logic                          out_sat,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire iirdf1_pkg::cfg_idx_t     cfg_index,
  input  wire iirdf1_pkg::coef_t        cfg_data
);

  iirdf1_pkg::coef_t    coef [iirdf1_pkg::NUM_REGS];
  iirdf1_pkg::sample_t  x;
  iirdf1_pkg::sample_t  xh [iirdf1_pkg::ORDER];
  iirdf1_pkg::sample_t  yh [iirdf1_pkg::ORDER];
  iirdf1_pkg::prod_t    prod;
  logic                 prod_sub;
  iirdf1_pkg::acc_t     acc;
  logic                 sat_pend;
  logic                 neg;
  iirdf1_pkg::rem_t     rem;
  iirdf1_pkg::quo_t     quo;

  iirdf1_pkg::reg_idx_t coef_idx;
  iirdf1_pkg::coef_t    coef_sel;
  iirdf1_pkg::sample_t  op_sel;
  iirdf1_pkg::coef_t    a0;
  iirdf1_pkg::dvs_t     a0_mag;
  iirdf1_pkg::mag_t     acc_mag;
  logic                 ovf;
  logic [iirdf1_pkg::DVS_W-1:0] trial;
  iirdf1_pkg::sample_t  y;
  logic                 y_sat;

  assign cfg_ready = 1'b1;

  // operand selection for the current tap
  always_comb begin
    coef_idx = cmd.fb ? {1'b0, cmd.tap} : {1'b1, cmd.tap};
    coef_sel = coef[coef_idx];
    op_sel   = x;
    for (int j = 1; j <= iirdf1_pkg::ORDER; j++) begin
      if (cmd.tap == iirdf1_pkg::tap_t'(j)) begin
        op_sel = cmd.fb ? yh[j-1] : xh[j-1];
      end
    end
  end

  // magnitudes and quotient range check
  always_comb begin
    a0      = coef[iirdf1_pkg::REG_DEN0];
    a0_mag  = a0[iirdf1_pkg::COEF_W-1] ? iirdf1_pkg::dvs_t'(-a0) : iirdf1_pkg::dvs_t'(a0);
    acc_mag = acc[iirdf1_pkg::ACC_W-1] ? iirdf1_pkg::mag_t'(-acc) : iirdf1_pkg::mag_t'(acc);
    ovf     = acc_mag >= {{(iirdf1_pkg::ACC_W - iirdf1_pkg::DVS_W - iirdf1_pkg::QUO_W){1'b0}},
                          a0_mag, {iirdf1_pkg::QUO_W{1'b0}}};
    trial   = {rem, quo[iirdf1_pkg::QUO_W-1]};
  end

  assign status.ovf      = ovf;
  assign status.out_free = !out_valid || out_ready;

  // final result with sign and clipping
  always_comb begin
    y     = '0;
    y_sat = 1'b0;
    if (cmd.zero) begin
      y     = '0;
      y_sat = 1'b0;
    end else if (sat_pend) begin
      y     = neg ? iirdf1_pkg::SAMPLE_MIN : iirdf1_pkg::SAMPLE_MAX;
      y_sat = 1'b1;
    end else if (neg) begin
      if (quo > iirdf1_pkg::QUO_NEG_LIM) begin
        y     = iirdf1_pkg::SAMPLE_MIN;
        y_sat = 1'b1;
      end else begin
        y = iirdf1_pkg::sample_t'(iirdf1_pkg::quo_t'(0) - quo);
      end
    end else begin
      if (quo > iirdf1_pkg::QUO_POS_LIM) begin
        y     = iirdf1_pkg::SAMPLE_MAX;
        y_sat = 1'b1;
      end else begin
        y = iirdf1_pkg::sample_t'(quo);
      end
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iirdf1_pkg::NUM_REGS; i++) begin
        coef[i] <= iirdf1_pkg::COEF_RESET[i];
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < iirdf1_pkg::cfg_idx_t'(iirdf1_pkg::NUM_REGS)) begin
      coef[cfg_index[iirdf1_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // histories, shifted when a result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < iirdf1_pkg::ORDER; j++) begin
        xh[j] <= '0;
        yh[j] <= '0;
      end
    end else if (cmd.commit) begin
      for (int j = 1; j < iirdf1_pkg::ORDER; j++) begin
        xh[j] <= xh[j-1];
        yh[j] <= yh[j-1];
      end
      xh[0] <= x;
      yh[0] <= y;
    end
  end

  // multiply, accumulate and serial divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= in_sample;
      acc <= '0;
    end
    if (cmd.mul) begin
      prod     <= coef_sel * op_sel;
      prod_sub <= cmd.fb;
    end
    if (cmd.acc) begin
      acc <= prod_sub ? acc - iirdf1_pkg::acc_t'(prod) : acc + iirdf1_pkg::acc_t'(prod);
    end
    if (cmd.check) begin
      sat_pend <= ovf;
      neg      <= acc[iirdf1_pkg::ACC_W-1] ^ a0[iirdf1_pkg::COEF_W-1];
      rem      <= acc_mag[iirdf1_pkg::REM_W+iirdf1_pkg::QUO_W-1:iirdf1_pkg::QUO_W];
      quo      <= acc_mag[iirdf1_pkg::QUO_W-1:0];
    end
    if (cmd.div) begin
      if (trial >= a0_mag) begin
        rem <= iirdf1_pkg::rem_t'(trial - a0_mag);
        quo <= {quo[iirdf1_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial[iirdf1_pkg::REM_W-1:0];
        quo <= {quo[iirdf1_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_sample <= y;
      out_sat    <= y_sat;
    end
  end

endmodule
`default_nettype wire

@@ design/iir_filter_direct_form_one.sv @@
// Direct form I IIR filter on a stream of signed Q1.15 samples.
// Input words arrive on s_axis (tdata = sample_in). Each accepted word yields
// exactly one output word on m_axis: tdata = sample_out, tuser = saturated.
// Eight Q4.14 coefficients are written on the cfg channel (index 0..3 are
// den_coef_0..3, 4..7 are num_coef_0..3; higher indexes are ignored); the
// user must write them while the filter is idle (unenforced); cfg_ready is always high.
// One sample is processed at a time: a multiply and an accumulate for each
// tap (2*ORDER+1 taps), then a range check, the divide by den_coef_0 at one
// quotient bit per cycle, and the commit into the output register.
// The commit waits until the output register is free, and s_axis_tready
// returns only after the commit, so no new word is taken before the last
// result is registered. Warm-up words and out-of-range results skip the divide.
// The first ORDER words after reset return zero.
// A finished result sits in the output register; while the receiver stalls
// the next word is still accepted and processed, and it waits for the
// register to empty before it commits.
// Reset clears the histories, the warm-up count and the output valid, and
// loads the default coefficients.
`default_nettype none
module iir_filter_direct_form_one (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
  output logic             m_axis_tuser,   // [0] saturated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);

  iirdf1_pkg::cmd_t    cmd;
  iirdf1_pkg::status_t status;
  iirdf1_pkg::sample_t out_sample;

  // sequencer
  iirdf1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, histories and output register
  iirdf1_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (iirdf1_pkg::sample_t'(s_axis_tdata)),
    .out_sample (out_sample),
    .out_sat    (m_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (iirdf1_pkg::coef_t'(cfg_data))
  );

  assign m_axis_tdata = out_sample;

endmodule
`default_nettype wire

@@ tb/iir_filter_direct_form_one_tb.sv @@
`timescale 1ns / 1ps
module iir_filter_direct_form_one_tb;
  import iirdf1_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int SET_ITEMS   = 110;
  localparam int RAND_SETS   = 12;
  localparam int DRAIN       = 4 * ORDER + 24;

  // one filtered word as it leaves the block
  typedef struct {
    sample_t  value;
    logic     sat;
  } filt_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = '0;
  coef_t       cfg_data = '0;

  iir_filter_direct_form_one i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // filter state mirrored by the testbench
  coef_t      coef_regs [NUM_REGS];
  sample_t    past_in   [3];
  sample_t    past_out  [3];
  int         warm_seen;

  sample_t    sample_queue [$];
  filt_word_t filtered_words [$];
  coef_t      plan_coefs [NUM_REGS];

  logic in_acc  = 1'b0;
  logic out_acc = 1'b0;
  bit   tx_gaps_on = 1'b1;
  bit   rx_gaps_on = 1'b1;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   stall_cycles = 0;
  int   mismatches = 0;
  int   words_checked = 0;
  int   clipped_words = 0;
  int   samples_sent = 0;
  int   coef_sets = 0;

  // direct form one step: zero during warm-up, else exact sum, divide by a0, truncate and clip
  function automatic void filter_step(input sample_t x, output filt_word_t res);
    longint acc;
    longint a0;
    longint q;
    int     j;
    res.value = '0;
    res.sat   = 1'b0;
    if (warm_seen < ORDER) begin
      warm_seen++;
    end else begin
      a0  = longint'(coef_regs[REG_DEN0]);
      acc = longint'(coef_regs[REG_NUM0]) * longint'(x);
      for (j = 1; j <= ORDER; j++) begin
        acc += longint'(coef_regs[REG_NUM0 + j]) * longint'(past_in[j-1]);
        acc -= longint'(coef_regs[REG_DEN0 + j]) * longint'(past_out[j-1]);
      end
      if (a0 == 0) begin
        res.value = (acc < 0) ? SAMPLE_MIN : SAMPLE_MAX;
        res.sat   = 1'b1;
      end else begin
        q = acc / a0;
        if (q > 32767) begin
          res.value = SAMPLE_MAX;
          res.sat   = 1'b1;
        end else if (q < -32768) begin
          res.value = SAMPLE_MIN;
          res.sat   = 1'b1;
        end else begin
          res.value = sample_t'(q);
        end
      end
    end
    for (j = ORDER - 1; j > 0; j--) begin
      past_in[j]  = past_in[j-1];
      past_out[j] = past_out[j-1];
    end
    past_in[0]  = x;
    past_out[0] = res.value;
  endfunction

  // predictor update and output check
  always @(posedge clk) begin : monitor
    filt_word_t want;
    filt_word_t res;
    in_acc  <= !rst && s_axis_tvalid && s_axis_tready;
    out_acc <= !rst && m_axis_tvalid && m_axis_tready;
    if (rst) begin
      coef_regs = '{18'sd16384, -18'sd11903, 18'sd0, 18'sd0,
                    18'sd2240, 18'sd2240, 18'sd0, 18'sd0};
      past_in   = '{default: '0};
      past_out  = '{default: '0};
      warm_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (filtered_words.size() == 0) begin
          $error("unexpected output word: sample_out %0d saturated %0b",
                 $signed(m_axis_tdata), m_axis_tuser);
          mismatches++;
        end else begin
          want = filtered_words.pop_front();
          if (want.sat) clipped_words++;
          if (m_axis_tdata !== want.value) begin
            $error("sample_out: expected %0d, actual %0d", want.value,
                   $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tuser !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, m_axis_tuser);
            mismatches++;
          end
        end
      end
      // indexes past the last register are dropped
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        coef_regs[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        filter_step(sample_t'(s_axis_tdata), res);
        filtered_words.push_back(res);
        samples_sent++;
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // sample driver, optional random gap between words
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_acc) begin
      if (in_wait > 0) begin
        in_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        s_axis_tdata  <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        in_wait = tx_gaps_on ? $urandom_range(0, 19) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output receiver with random stalls and the long hold
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_left = LONG_HOLD;
        hold_served++;
      end
      if (out_acc)
        out_wait = rx_gaps_on ? $urandom_range(0, 19) : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() > 0 || s_axis_tvalid || filtered_words.size() > 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // one coefficient word, valid is left high for the next one
  task automatic cfg_write(input cfg_idx_t idx, input coef_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // whole coefficient set plus one write to an unused index
  task automatic write_coefs();
    int k;
    int junk_pos;
    junk_pos = $urandom_range(0, NUM_REGS);
    for (k = 0; k <= NUM_REGS; k++) begin
      if (k == junk_pos)
        cfg_write(cfg_idx_t'(NUM_REGS + $urandom_range(0, 7)), coef_t'($urandom));
      if (k < NUM_REGS)
        cfg_write(cfg_idx_t'(k), plan_coefs[k]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    coef_sets++;
  endtask

  function automatic coef_t span(input int lo, input int hi);
    return coef_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // coefficient sets of a few flavors
  function automatic void plan_set(input int style);
    int k;
    for (k = 0; k < NUM_REGS; k++) begin
      case (style)
        0: begin
          plan_coefs[k] = (k < REG_NUM0) ? span(-8192, 8192) : span(-4096, 4096);
        end
        1: begin
          plan_coefs[k] = coef_t'($urandom);
        end
        2: begin
          plan_coefs[k] = span(-20000, 20000);
        end
        default: begin
          plan_coefs[k] = coef_t'($urandom);
        end
      endcase
    end
    case (style)
      0: plan_coefs[REG_DEN0] = 18'sd16384;
      2: plan_coefs[REG_DEN0] = span(-4, 4);
      3: plan_coefs[REG_DEN0] = ($urandom_range(0, 1) == 1) ? span(65536, 131071)
                                                            : span(-131072, -65536);
      default: ;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return sample_t'($urandom);
    if (r < 65) begin
      case ($urandom_range(0, 4))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return sample_t'(0);
        3: return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    return sample_t'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  // stimulus
  initial begin : stimulus
    sample_t corner_samples [];
    int      p;
    int      n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients, warm-up and input extremes
    corner_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                       16'sd0, 16'sd1, -16'sd1, 16'sh5555, -16'sh5556, 16'sd0};
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    wait_idle();

    // tiny divisor, extreme taps: clipping both ways
    plan_coefs = '{18'sd1, 18'sd131071, -18'sd131072, -18'sd131072,
                   18'sd131071, -18'sd131072, 18'sd131071, 18'sd131071};
    write_coefs();
    corner_samples = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1};
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    wait_idle();

    // zero divisor with zero, positive and negative sums
    plan_coefs = '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd1, 18'sd0, 18'sd0, 18'sd0};
    write_coefs();
    corner_samples = '{16'sd0, 16'sd100, -16'sd100};
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    wait_idle();

    // most negative divisor
    plan_coefs = '{-18'sd131072, -18'sd131072, 18'sd0, 18'sd0,
                   -18'sd131072, 18'sd131071, -18'sd131072, 18'sd0};
    write_coefs();
    corner_samples = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 16'sd1};
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    wait_idle();

    // random coefficient sets and random samples
    for (p = 0; p < RAND_SETS; p++) begin
      plan_set(p % 4);
      write_coefs();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        // receiver holds off while the sender keeps offering words
        tx_gaps_on = 1'b0;
        hold_requests++;
      end
      for (n = 0; n < SET_ITEMS; n++) sample_queue.push_back(pick_sample());
      wait_idle();
    end

    repeat (DRAIN) @(posedge clk);
    $display("filtered %0d samples under %0d coefficient sets, order %0d",
             samples_sent, coef_sets + 1, ORDER);
    $display("%0d output words checked, %0d of them clipped or zero-divisor",
             words_checked, clipped_words);
    if (mismatches == 0 && filtered_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ iir_filter_direct_form_one.f @@
design/iirdf1_pkg.sv
design/iirdf1_ctrl.sv
design/iirdf1_datapath.sv
design/iir_filter_direct_form_one.sv
tb/iir_filter_direct_form_one_tb.sv
